// ===== src/wht_pkg.sv =====
// ============================================================================
// wht_pkg - Walsh-Hadamard transform engine package
// Shared constants, input kind codes and controller/datapath interface types.
// ============================================================================
`default_nettype none

package wht_pkg;

    localparam int MAX_LOG_DEF      = 12;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int INDEX_W = 12;
    localparam int COEF_W  = 28;
    localparam int KIND_W  = 2;
    localparam int OUT_W   = ((COEF_W + INDEX_W + 7) / 8) * 8;
    localparam int CFG_W   = 4;

    localparam logic [CFG_W-1:0] LOG_SIZE_RST = 4'd12;

    // item kinds on s_tuser
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_XFORM = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic mem_wr_in;   // store sample from the accepted item
        logic rd_load;     // read entry at the accepted item's index
        logic out_load;    // move read data into the output register
        logic bf_init;     // restart butterfly walk
        logic bf_load;     // fetch butterfly operands
        logic bf_wr_sum;   // write x+y
        logic bf_wr_diff;  // write x-y and advance
    } wht_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_busy;    // output register full and not taken
        logic single;      // length 1: nothing to do
        logic xf_end;      // current butterfly is the last one
    } wht_stat_t;

endpackage

`default_nettype wire

// ===== src/wht_ctrl.sv =====
// ============================================================================
// wht_ctrl - Walsh-Hadamard transform controller
// One-hot sequencer for item acceptance, reads and the butterfly walk.
// ============================================================================
`default_nettype none

module wht_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    input  wire logic [wht_pkg::KIND_W-1:0]  s_tuser,
    output logic                             s_tready,
    output wht_pkg::wht_cmd_t                cmd,
    input  wht_pkg::wht_stat_t               stat
);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_RDATA   = 5'b00010,
        S_BF_RD   = 5'b00100,
        S_BF_SUM  = 5'b01000,
        S_BF_DIFF = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        wht_pkg::KIND_WRITE:
                        begin
                            cmd.mem_wr_in = 1'b1;
                        end
                        wht_pkg::KIND_XFORM:
                        begin
                            cmd.bf_init = 1'b1;
                            if (!stat.single)
                            begin
                                state_next = S_BF_RD;
                            end
                        end
                        wht_pkg::KIND_READ:
                        begin
                            cmd.rd_load = 1'b1;
                            state_next  = S_RDATA;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RDATA:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_BF_RD:
            begin
                cmd.bf_load = 1'b1;
                state_next  = S_BF_SUM;
            end
            S_BF_SUM:
            begin
                cmd.bf_wr_sum = 1'b1;
                state_next    = S_BF_DIFF;
            end
            S_BF_DIFF:
            begin
                cmd.bf_wr_diff = 1'b1;
                state_next     = stat.xf_end ? S_IDLE : S_BF_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/wht_datapath.sv =====
// ============================================================================
// wht_datapath - Walsh-Hadamard transform datapath
// Work store, butterfly address walk, add/subtract and output register.
// ============================================================================
`default_nettype none

module wht_datapath #(
    parameter int MAX_LOG      = wht_pkg::MAX_LOG_DEF,
    parameter int SAMPLE_WIDTH = wht_pkg::SAMPLE_WIDTH_DEF,
    parameter int LGW          = $clog2(MAX_LOG + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wht_pkg::wht_cmd_t                  cmd,
    output wht_pkg::wht_stat_t                 stat,
    input  wire logic [wht_pkg::INDEX_W-1:0]   idx,
    input  wire logic [SAMPLE_WIDTH-1:0]       sample,
    input  wire logic [LGW-1:0]                lg_eff,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [wht_pkg::OUT_W-1:0]          m_tdata
);

    localparam int AW    = MAX_LOG;
    localparam int EW    = SAMPLE_WIDTH + MAX_LOG;
    localparam int DEPTH = 1 << AW;
    localparam int IW    = wht_pkg::INDEX_W;
    localparam int CW    = wht_pkg::COEF_W;

    logic [EW-1:0] mem [DEPTH];

    logic [EW-1:0] rda_reg, rdb_reg;
    logic [AW-1:0] j_reg, j_next;
    logic [AW-1:0] span_reg, span_next;
    logic          beyond_reg;
    logic [IW-1:0] rpos_reg;
    logic          out_valid_reg;
    logic [CW-1:0] coef_reg;
    logic [IW-1:0] pos_reg;

    logic [AW:0]      n_full;
    logic [AW-1:0]    n_m1, half, j_hi, j_step;
    logic [AW+IW-1:0] idx_wide;
    logic [AW-1:0]    idx_addr;
    logic             in_store, beyond;
    logic             we;
    logic [AW-1:0]    waddr, addr_a;
    logic [EW-1:0]    wdata, sample_ext;
    logic [EW+CW-1:0] coef_wide;
    logic             stage_end;

    // length in use
    assign n_full = {{AW{1'b0}}, 1'b1} << lg_eff;
    assign n_m1   = AW'(n_full - 1'b1);
    assign half   = AW'(n_full >> 1);

    // index into store address space
    assign idx_wide = {{AW{1'b0}}, idx};
    assign idx_addr = idx_wide[AW-1:0];
    assign in_store = (idx_wide >> AW) == '0;
    assign beyond   = (idx_wide >> lg_eff) != '0;

    assign sample_ext = {{MAX_LOG{sample[SAMPLE_WIDTH-1]}}, sample};

    // butterfly partner and walk
    assign j_hi      = j_reg | span_reg;
    assign stage_end = (j_hi == n_m1);
    assign j_step    = j_reg + 1'b1;

    always_comb
    begin
        j_next    = j_step;
        span_next = span_reg;
        if ((j_step & span_reg) != '0)
        begin
            j_next = j_step + span_reg;
        end
        if (stage_end)
        begin
            j_next    = '0;
            span_next = span_reg << 1;
        end
    end

    // single write port
    assign we    = (cmd.mem_wr_in && in_store) || cmd.bf_wr_sum || cmd.bf_wr_diff;
    assign waddr = cmd.bf_wr_sum ? j_reg : (cmd.bf_wr_diff ? j_hi : idx_addr);
    assign wdata = cmd.bf_wr_sum ? (rda_reg + rdb_reg) :
                   (cmd.bf_wr_diff ? (rda_reg - rdb_reg) : sample_ext);

    assign addr_a = cmd.bf_load ? j_reg : idx_addr;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.bf_load || cmd.rd_load)
        begin
            rda_reg <= mem[addr_a];
        end
        if (cmd.bf_load)
        begin
            rdb_reg <= mem[j_hi];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg    <= '0;
            span_reg <= '0;
        end
        else if (cmd.bf_init)
        begin
            j_reg    <= '0;
            span_reg <= {{(AW-1){1'b0}}, 1'b1};
        end
        else if (cmd.bf_wr_diff)
        begin
            j_reg    <= j_next;
            span_reg <= span_next;
        end
    end

    // read bookkeeping (payload)
    always_ff @(posedge clk)
    begin
        if (cmd.rd_load)
        begin
            beyond_reg <= beyond;
            rpos_reg   <= idx;
        end
    end

    // coefficient is the low bits of the entry, zero-filled if the entry is narrower
    assign coef_wide = {{CW{1'b0}}, rda_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            coef_reg <= beyond_reg ? '0 : coef_wide[CW-1:0];
            pos_reg  <= rpos_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = wht_pkg::OUT_W'({pos_reg, coef_reg});

    assign stat.out_busy = out_valid_reg && !m_tready;
    assign stat.single   = (lg_eff == '0);
    assign stat.xf_end   = stage_end && (span_reg == half);

endmodule

`default_nettype wire

// ===== src/walsh_hadamard_transform.sv =====
// A write item is stored as it is accepted; a read item goes via the read-data
// register to the output register; a transform walks (N/2)*log2(N) butterflies
// for N = 2^log_size, each a read, a sum write and a difference write, as the
// store has one write port. One item at a time; a read holds the input until its
// result enters the output register, so a waiting result stalls the next read.
// Reset: rst_n asynchronous, active low; log_size returns to 12, control clears.
// ============================================================================
// walsh_hadamard_transform - integer fast Walsh-Hadamard transform engine
// Unnormalized in-place transform over a 2^MAX_LOG entry work store, fed by
// write/transform/read items on a stream port, length set over APB.
// The work store is not cleared; entries hold nothing defined until written.
// ============================================================================
`default_nettype none

module walsh_hadamard_transform #(
    parameter int MAX_LOG      = wht_pkg::MAX_LOG_DEF,
    parameter int SAMPLE_WIDTH = wht_pkg::SAMPLE_WIDTH_DEF,
    parameter int IN_W         = ((wht_pkg::INDEX_W + SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // input items
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // s_tdata, low bit up: index[11:0], sample[SAMPLE_WIDTH-1:0], zero fill
    input  wire logic [IN_W-1:0]              s_tdata,
    // s_tuser: kind[1:0]
    input  wire logic [wht_pkg::KIND_W-1:0]   s_tuser,
    // result items
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // m_tdata, low bit up: coefficient[27:0], position[11:0]
    output logic [wht_pkg::OUT_W-1:0]         m_tdata,
    // configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int LGW = $clog2(MAX_LOG + 1);

    wht_pkg::wht_cmd_t  cmd;
    wht_pkg::wht_stat_t stat;

    logic [wht_pkg::CFG_W-1:0]   log_size_reg;
    logic [LGW-1:0]              lg_eff;
    logic                        cfg_wr;
    logic [wht_pkg::INDEX_W-1:0] idx;
    logic [SAMPLE_WIDTH-1:0]     sample;

    // APB: single register log_size at byte address 0; paddr[1:0] unused
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_size_reg <= wht_pkg::LOG_SIZE_RST;
        end
        else if (cfg_wr)
        begin
            log_size_reg <= pwdata[wht_pkg::CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == 1'b0) ? 32'(log_size_reg) : 32'd0;

    // lengths above the store act as the full store
    assign lg_eff = (32'(log_size_reg) > MAX_LOG) ? LGW'(MAX_LOG) : LGW'(log_size_reg);

    // unpack input item
    assign idx    = s_tdata[wht_pkg::INDEX_W-1:0];
    assign sample = s_tdata[wht_pkg::INDEX_W +: SAMPLE_WIDTH];

    wht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    wht_datapath #(
        .MAX_LOG      (MAX_LOG),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .LGW          (LGW)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .idx      (idx),
        .sample   (sample),
        .lg_eff   (lg_eff),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== src/wht_checker.sv =====
// ============================================================================
// wht_checker - port-level checks for the Walsh-Hadamard transform engine
// Handshake timing of writes, reads and result loading seen at the ports.
// ============================================================================
`default_nettype none

module wht_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic [wht_pkg::KIND_W-1:0]  s_tuser,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [wht_pkg::OUT_W-1:0]   m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a write item finishes in its accept cycle
    a_write_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == wht_pkg::KIND_WRITE) |=> s_tready)
        else $error("write item held the input");

    // a read item waits for its data before the next item
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == wht_pkg::KIND_READ) |=> !s_tready)
        else $error("input taken during read");

    // a result appears only after the read-data cycle
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result without read");

endmodule

bind walsh_hadamard_transform wht_checker u_wht_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== dv/wht_coef_checker.sv =====
// ============================================================================
// wht_coef_checker - coefficient predictor and result checker
// Watches the item, result and APB channels of the transform engine, keeps
// its own copy of the work store and length register, and compares every
// returned coefficient with the oldest prediction.
// ============================================================================
`default_nettype none

module wht_coef_checker
    import wht_pkg::*;
#(
    parameter int               IN_W          = 32,
    parameter logic [2:0]       LOG_SIZE_ADDR = 3'd0
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    input  wire logic                s_tready,
    input  wire logic [IN_W-1:0]     s_tdata,
    input  wire logic [KIND_W-1:0]   s_tuser,
    input  wire logic                m_tvalid,
    input  wire logic                m_tready,
    input  wire logic [OUT_W-1:0]    m_tdata,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    input  wire logic                pready,
    output int                       fail_count,
    output int                       pending
);

    localparam int ENTRY_W = SAMPLE_WIDTH_DEF + MAX_LOG_DEF;

    // packed so that coef lands in the low bits, as on m_tdata
    typedef struct packed {
        logic [INDEX_W-1:0] pos;
        logic [COEF_W-1:0]  coef;
    } coef_result_t;

    logic [ENTRY_W-1:0] coef_store [0:(1 << MAX_LOG_DEF)-1];
    logic [CFG_W-1:0]   log_size_q;
    coef_result_t       coef_expected [$];

    function automatic int unsigned used_length(input logic [CFG_W-1:0] lg);
        return (lg > MAX_LOG_DEF) ? (1 << MAX_LOG_DEF) : (1 << lg);
    endfunction

    // in-place butterflies, span 1, 2, 4 ... with wrap at the entry width
    function automatic void run_butterflies(input int unsigned n);
        int unsigned        span;
        int unsigned        base;
        int unsigned        j;
        logic [ENTRY_W-1:0] x;
        logic [ENTRY_W-1:0] y;
        for (span = 1; span < n; span = span * 2)
            for (base = 0; base < n; base = base + 2 * span)
                for (j = base; j < base + span; j++)
                begin
                    x = coef_store[j];
                    y = coef_store[j + span];
                    coef_store[j]        = x + y;
                    coef_store[j + span] = x - y;
                end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        coef_result_t       got;
        coef_result_t       want;
        logic [INDEX_W-1:0] idx;
        logic [15:0]        smp;
        if (!rst_n)
        begin
            log_size_q = LOG_SIZE_RST;
            coef_expected.delete();
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == LOG_SIZE_ADDR)
                log_size_q = pwdata[CFG_W-1:0];

            if (m_tvalid && m_tready)
            begin
                got = m_tdata[COEF_W+INDEX_W-1:0];
                if (coef_expected.size() == 0)
                begin
                    $error("unexpected result: position %0d, coefficient %0d",
                           got.pos, $signed(got.coef));
                    fail_count++;
                end
                else
                begin
                    want = coef_expected.pop_front();
                    if (got.coef !== want.coef)
                    begin
                        $error("coefficient: expected %0d, got %0d",
                               $signed(want.coef), $signed(got.coef));
                        fail_count++;
                    end
                    if (got.pos !== want.pos)
                    begin
                        $error("position: expected %0d, got %0d", want.pos, got.pos);
                        fail_count++;
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                idx = s_tdata[INDEX_W-1:0];
                smp = s_tdata[INDEX_W+15:INDEX_W];
                case (s_tuser)
                    KIND_WRITE: coef_store[idx] = {{(ENTRY_W-16){smp[15]}}, smp};
                    KIND_XFORM: run_butterflies(used_length(log_size_q));
                    KIND_READ:
                    begin
                        want.pos  = idx;
                        want.coef = (idx < used_length(log_size_q)) ?
                                    coef_store[idx][COEF_W-1:0] : '0;
                        coef_expected = {coef_expected, want};
                    end
                    default: ;
                endcase
            end
            pending = coef_expected.size();
        end
    end

endmodule

`default_nettype wire

// ===== dv/walsh_hadamard_transform_tb.sv =====
// ============================================================================
// walsh_hadamard_transform_tb - stimulus and verdict for the WHT engine
// Directed items over the field extremes and corner cases, then random phases
// at many transform lengths (0, 1, 12 and the out-of-range 13..15 among them),
// with bursty input, a stalling result side and a separate checker module.
// ============================================================================
`default_nettype none

module walsh_hadamard_transform_tb;

    import wht_pkg::*;

    localparam int         IN_W          = ((INDEX_W + SAMPLE_WIDTH_DEF + 7) / 8) * 8;
    localparam logic [2:0] ADDR_LOG_SIZE = 3'd0;
    // kind code 3 is unused; the block must drop it without a result
    localparam logic [KIND_W-1:0] KIND_IDLE = 2'd3;
    localparam int         STORE_DEPTH   = 1 << MAX_LOG_DEF;
    localparam int         PHASE_ITEMS   = 8;
    // entries filled with samples stop here; longer lengths skip transforms
    localparam int         FILL_CAP      = 256;
    localparam int         DRAIN_LIMIT   = 200000;

    // result-side stall patterns, each held for a random stretch
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_CHOKE, RX_PACED} rx_mode_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;
    logic [KIND_W-1:0] s_tuser  = KIND_WRITE;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [2:0]        paddr    = ADDR_LOG_SIZE;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;

    int                fail_count;
    int                pending;

    int                burst_left = 0;
    rx_mode_t          rx_mode    = RX_OPEN;
    int                rx_left    = 0;
    int                rx_tick    = 0;
    logic [CFG_W-1:0]  phase_log [0:14];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    walsh_hadamard_transform u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),     // index[11:0], sample[27:12], zero fill
        .s_tuser  (s_tuser),     // kind[1:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),     // coefficient[27:0], position[39:28]
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    wht_coef_checker #(
        .IN_W          (IN_W),
        .LOG_SIZE_ADDR (ADDR_LOG_SIZE)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Result side: pick a stall pattern, hold it until rx_left runs out. RX_OPEN
    // gives the stall-free stretches; RX_CHOKE holds results for a long time.
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 80);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:  m_tready <= 1'b1;
            RX_COIN:  m_tready <= 1'($urandom_range(0, 1));
            RX_CHOKE: m_tready <= ($urandom_range(0, 4) == 0);
            default:  m_tready <= (rx_tick % 3 == 0);
        endcase
    end

    // Samples lean on the extremes and on 0 / -1 now and then.
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Send one item. Bursts of random length (now and then a long one) are
    // separated by random gaps; a gap of zero merges two bursts. Called and
    // returns at a falling edge, so tvalid stays high across back-to-back items.
    task automatic push_item(input logic [KIND_W-1:0] kind, input logic [11:0] idx,
                             input logic [15:0] smp);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) :
                                                       $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(IN_W-INDEX_W-16){1'b0}}, smp, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
    endtask

    // Stop sending and let all pending reads come back. Every phase ends with
    // a read, so an empty queue also means no transform is still running.
    task automatic drain_results();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (pending != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (4) @(negedge clk);
    endtask

    // APB write of log_size, only with the engine idle
    task automatic write_log_size(input logic [CFG_W-1:0] lg);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_LOG_SIZE;
        pwdata  <= {{(32-CFG_W){1'b0}}, lg};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin : stimulus
        int          n;
        int          p;
        int          i;
        int          done;
        int          run;
        int          pick;
        int          filled_len;
        int          rd_lim;
        logic [11:0] idx;

        // mostly small lengths; 15, 13, 14 all act as the full 4096
        phase_log = '{4'd2, 4'd0, 4'd5, 4'd1, 4'd3, 4'd8, 4'd15, 4'd6,
                      4'd12, 4'd4, 4'd13, 4'd7, 4'd10, 4'd14, 4'd3};

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed ---
        // Reset length is 4096: only touch entries written here.
        push_item(KIND_WRITE, 12'd4095, 16'h7FFF);
        push_item(KIND_READ,  12'd4095, 16'h0000);
        push_item(KIND_WRITE, 12'd0,    16'hFFFF);
        push_item(KIND_READ,  12'd0,    16'hFFFF);

        // length 2: extremes through one butterfly, reads past the size,
        // an unused kind, a write beyond the size that must still be stored
        write_log_size(4'd1);
        push_item(KIND_WRITE, 12'd0,    16'h7FFF);
        push_item(KIND_WRITE, 12'd1,    16'h8000);
        push_item(KIND_READ,  12'd0,    16'h0000);
        push_item(KIND_READ,  12'd1,    16'h0000);
        push_item(KIND_XFORM, 12'd0,    16'h0000);
        push_item(KIND_READ,  12'd0,    16'h0000);
        push_item(KIND_READ,  12'd1,    16'h0000);
        push_item(KIND_READ,  12'd2,    16'h0000);
        push_item(KIND_READ,  12'd4095, 16'hFFFF);
        push_item(KIND_IDLE,  12'hFFF,  16'hFFFF);
        push_item(KIND_WRITE, 12'd2048, 16'h1234);
        push_item(KIND_XFORM, 12'hFFF,  16'hFFFF);
        push_item(KIND_READ,  12'd0,    16'h0000);
        push_item(KIND_READ,  12'd1,    16'h0000);

        // length 1: transform leaves entry 0 alone, index 1 is out of range
        write_log_size(4'd0);
        push_item(KIND_XFORM, 12'd0, 16'h0000);
        push_item(KIND_READ,  12'd0, 16'h0000);
        push_item(KIND_READ,  12'd1, 16'h0000);
        filled_len = 2;

        // --- random phases ---
        for (p = 0; p < 15; p++)
        begin
            write_log_size(phase_log[p]);
            n = (phase_log[p] > MAX_LOG_DEF) ? STORE_DEPTH : (1 << phase_log[p]);

            // Every entry a transform or read touches must hold a sample.
            // Filling stops at FILL_CAP: longer lengths read only filled
            // entries (or past the size) and run no transform.
            for (i = filled_len; i < n && i < FILL_CAP; i++)
                push_item(KIND_WRITE, 12'(i), pick_sample());
            if (n > filled_len)
                filled_len = (n < FILL_CAP) ? n : FILL_CAP;
            rd_lim = (n < filled_len) ? n : filled_len;

            done = 0;
            while (done < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 6)
                    push_item(KIND_IDLE, 12'($urandom), 16'($urandom));
                else if (pick < 40)
                begin
                    // writes land inside the length or anywhere in the store
                    idx = $urandom_range(0, 1) ? 12'($urandom_range(0, n - 1)) :
                                                 12'($urandom);
                    push_item(KIND_WRITE, idx, pick_sample());
                    done++;
                end
                else if (pick < 82)
                begin
                    idx = $urandom_range(0, 1) ? 12'($urandom_range(0, rd_lim - 1)) :
                                                 12'($urandom);
                    if (idx < n && idx >= rd_lim)
                        idx = 12'(idx % rd_lim);
                    push_item(KIND_READ, idx, 16'($urandom));
                    done++;
                end
                else if (n <= 16 && pick < 88)
                begin
                    // long run of transforms: values grow until they wrap
                    run = $urandom_range(8, 40);
                    repeat (run)
                        push_item(KIND_XFORM, 12'($urandom), 16'($urandom));
                    done += run;
                end
                else if (n <= filled_len)
                begin
                    push_item(KIND_XFORM, 12'($urandom), 16'($urandom));
                    done++;
                end
            end
            push_item(KIND_READ, 12'($urandom_range(0, rd_lim - 1)), 16'($urandom));
        end

        drain_results();
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #6000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
src/wht_pkg.sv
src/wht_ctrl.sv
src/wht_datapath.sv
src/walsh_hadamard_transform.sv
src/wht_checker.sv
dv/wht_coef_checker.sv
dv/walsh_hadamard_transform_tb.sv
